// ===== src/lfumc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfumc_pkg: shared types and constants for the LFU counter update pipeline
// Widths, register map and the payload carried through the divide stages.
// ----------------------------------------------------------------------------
package lfumc_pkg;

	localparam int STAMP_BITS  = 16;
	localparam int RANDOM_BITS = 16;
	localparam int CNT_BITS    = 8;
	localparam int FACTOR_BITS = 8;
	localparam int PERIOD_BITS = 16;

	// quotient bits resolved by each divide stage, and the stage count
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = CNT_BITS / DIV_PER_STAGE;

	// remainder compare width: widest operand plus the quotient shift
	localparam int CMP_BITS = ((STAMP_BITS > PERIOD_BITS) ? STAMP_BITS : PERIOD_BITS)
		+ CNT_BITS;

	localparam int PROD_BITS = CNT_BITS + FACTOR_BITS;
	localparam int TEST_BITS = RANDOM_BITS + PROD_BITS;
	localparam int SHIFT_BITS = $clog2(CNT_BITS);

	localparam logic [CNT_BITS-1:0] CNT_BASE = CNT_BITS'(5);
	localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(255);

	// APB register map, selected by paddr[2]
	localparam int ADDR_BITS = 3;
	localparam logic REG_LOG_FACTOR   = 1'b0;
	localparam logic REG_DECAY_PERIOD = 1'b1;

	localparam logic [FACTOR_BITS-1:0] LOG_FACTOR_RST   = FACTOR_BITS'(10);
	localparam logic [PERIOD_BITS-1:0] DECAY_PERIOD_RST = PERIOD_BITS'(1);

	typedef struct packed {
		logic [STAMP_BITS-1:0]  rem;
		logic [CNT_BITS-1:0]    quo;
		logic                   sat;
		logic                   keep;
		logic [CNT_BITS-1:0]    count;
		logic [RANDOM_BITS-1:0] rnd;
		logic [STAMP_BITS-1:0]  now;
	} lfumc_div_t;

endpackage

// ===== src/lfumc_in_if.sv =====
// ----------------------------------------------------------------------------
// lfumc_in_if: access channel
// One beat carries an entry's stamp, counter, current minute and random draw.
// ----------------------------------------------------------------------------
interface lfumc_in_if;
	import lfumc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STAMP_BITS-1:0]  stamp_minutes;
	logic [CNT_BITS-1:0]    count_in;
	logic [STAMP_BITS-1:0]  cur_minutes;
	logic [RANDOM_BITS-1:0] random_fraction;

	modport source (
		output valid, stamp_minutes, count_in, cur_minutes, random_fraction,
		input  ready
	);
	modport sink (
		input  valid, stamp_minutes, count_in, cur_minutes, random_fraction,
		output ready
	);
endinterface

// ===== src/lfumc_out_if.sv =====
// ----------------------------------------------------------------------------
// lfumc_out_if: result channel
// One beat carries the decayed counter, the new counter, the flag and stamp.
// ----------------------------------------------------------------------------
interface lfumc_out_if;
	import lfumc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CNT_BITS-1:0]   decayed_count;
	logic [CNT_BITS-1:0]   count_out;
	logic                  incremented;
	logic [STAMP_BITS-1:0] stamp_out;

	modport source (
		output valid, decayed_count, count_out, incremented, stamp_out,
		input  ready
	);
	modport sink (
		input  valid, decayed_count, count_out, incremented, stamp_out,
		output ready
	);
endinterface

// ===== src/lfumc_div_stage.sv =====
// ----------------------------------------------------------------------------
// lfumc_div_stage: one registered stage of the decay-step divider
// Resolves two quotient bits of elapsed / decay_period by restoring steps.
// ----------------------------------------------------------------------------
module lfumc_div_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  lfumc_pkg::lfumc_div_t               in_d,
	input  logic [lfumc_pkg::PERIOD_BITS-1:0]   period,
	input  logic [lfumc_pkg::SHIFT_BITS-1:0]    top_bit,
	output logic                                out_valid,
	output lfumc_pkg::lfumc_div_t               out_d
);
	import lfumc_pkg::*;

	lfumc_div_t mid_d;
	lfumc_div_t nxt_d;

	function automatic lfumc_div_t div_step(input lfumc_div_t d,
		input logic [PERIOD_BITS-1:0] p, input logic [SHIFT_BITS-1:0] k);
		logic [CMP_BITS-1:0] r_ext;
		logic [CMP_BITS-1:0] p_ext;
		lfumc_div_t          o;
		o     = d;
		r_ext = CMP_BITS'(d.rem);
		p_ext = CMP_BITS'(p) << k;
		if (r_ext >= p_ext) begin
			// p_ext never exceeds rem here, so the truncation is exact
			o.rem    = d.rem - STAMP_BITS'(p_ext);
			o.quo[k] = 1'b1;
		end
		return o;
	endfunction

	always_comb begin
		mid_d = div_step(in_d, period, top_bit);
		nxt_d = div_step(mid_d, period, top_bit - SHIFT_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_d <= nxt_d;
		end
	end

endmodule

// ===== src/lfu_morris_counter_update.sv =====
// ----------------------------------------------------------------------------
// lfu_morris_counter_update: LFU access-counter aging and Morris increment
// Ages an 8-bit logarithmic counter by elapsed minutes / decay period, then
// applies a probabilistic increment whose odds fall as the counter grows.
//
//   channel   dir  handshake       payload
//   access    in   valid/ready     stamp_minutes, count_in, cur_minutes,
//                                  random_fraction
//   result    out  valid/ready     decayed_count, count_out, incremented,
//                                  stamp_out
//   apb       in   psel/penable    log_factor @0x0, decay_period @0x4
//
// One beat enters per cycle unless every stage is full and the result stalls;
// each result is offered once its access beat has passed the nine register
// stages: front stage, four two-bit divide stages, decay select, two multiply
// stages, output register. The divider and multipliers set the depth.
// Each stage holds while its successor is full and stalled, so empty slots
// are filled and access beats are still taken while a result waits, until
// every stage holds a beat.
// arst_n clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module lfu_morris_counter_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lfumc_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	lfumc_in_if.sink                          access,
	lfumc_out_if.source                       result
);
	import lfumc_pkg::*;

	// configuration
	logic [FACTOR_BITS-1:0] log_factor_q;
	logic [PERIOD_BITS-1:0] decay_period_q;

	// front stage
	logic                  v_s1;
	lfumc_div_t            d_s1;
	lfumc_div_t            front_d;
	logic [STAMP_BITS-1:0] elapsed;
	logic                  en_s1;

	// divide stages
	logic                  div_v  [DIV_STAGES];
	lfumc_div_t            div_d  [DIV_STAGES];
	logic                  div_en [DIV_STAGES];

	// decay select
	logic                   v_s6;
	logic [CNT_BITS-1:0]    dec_s6;
	logic [CNT_BITS-1:0]    base_s6;
	logic [RANDOM_BITS-1:0] rnd_s6;
	logic [STAMP_BITS-1:0]  now_s6;
	logic                   en_s6;
	lfumc_div_t             last_d;
	logic [CNT_BITS-1:0]    dec_nxt;

	// first multiply
	logic                   v_s7;
	logic [CNT_BITS-1:0]    dec_s7;
	logic [PROD_BITS-1:0]   scale_s7;
	logic [RANDOM_BITS-1:0] rnd_s7;
	logic [STAMP_BITS-1:0]  now_s7;
	logic                   en_s7;

	// second multiply
	logic                   v_s8;
	logic [CNT_BITS-1:0]    dec_s8;
	logic [TEST_BITS-1:0]   test_s8;
	logic [STAMP_BITS-1:0]  now_s8;
	logic                   en_s8;
	logic [PROD_BITS-1:0]   denom;

	// output register
	logic                  v_s9;
	logic [CNT_BITS-1:0]   dec_s9;
	logic [CNT_BITS-1:0]   cnt_s9;
	logic                  inc_s9;
	logic [STAMP_BITS-1:0] now_s9;
	logic                  en_s9;
	logic                  take;

	// ------------------------------------------------------------------
	// APB registers
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_factor_q   <= LOG_FACTOR_RST;
			decay_period_q <= DECAY_PERIOD_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_LOG_FACTOR:   log_factor_q   <= pwdata[FACTOR_BITS-1:0];
				REG_DECAY_PERIOD: decay_period_q <= pwdata[PERIOD_BITS-1:0];
				default:          log_factor_q   <= log_factor_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LOG_FACTOR:   prdata = 32'(log_factor_q);
			REG_DECAY_PERIOD: prdata = 32'(decay_period_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage enables: a stage advances when empty or when its successor does
	// ------------------------------------------------------------------
	assign en_s9 = !v_s9 || result.ready;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign div_en[DIV_STAGES-1] = !div_v[DIV_STAGES-1] || en_s6;
	for (genvar j = 0; j < DIV_STAGES - 1; j++) begin : g_en
		assign div_en[j] = !div_v[j] || div_en[j+1];
	end
	assign en_s1 = !v_s1 || div_en[0];
	assign access.ready = en_s1;

	// ------------------------------------------------------------------
	// Front: elapsed minutes with a single wrap (one short on wrap)
	// ------------------------------------------------------------------
	always_comb begin
		elapsed = access.cur_minutes - access.stamp_minutes
			- STAMP_BITS'(access.cur_minutes < access.stamp_minutes);
		front_d.rem   = elapsed;
		front_d.quo   = '0;
		// quotient of 256 or more clears any counter
		front_d.sat   = CMP_BITS'(elapsed) >= (CMP_BITS'(decay_period_q) << CNT_BITS);
		front_d.keep  = (decay_period_q == '0);
		front_d.count = access.count_in;
		front_d.rnd   = access.random_fraction;
		front_d.now   = access.cur_minutes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && access.valid) begin
			d_s1 <= front_d;
		end
	end

	// ------------------------------------------------------------------
	// Divider: two quotient bits per stage, most significant first
	// ------------------------------------------------------------------
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		if (j == 0) begin : g_first
			lfumc_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (div_en[j]),
				.in_valid  (v_s1),
				.in_d      (d_s1),
				.period    (decay_period_q),
				.top_bit   (SHIFT_BITS'(CNT_BITS - 1 - DIV_PER_STAGE * j)),
				.out_valid (div_v[j]),
				.out_d     (div_d[j])
			);
		end else begin : g_next
			lfumc_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (div_en[j]),
				.in_valid  (div_v[j-1]),
				.in_d      (div_d[j-1]),
				.period    (decay_period_q),
				.top_bit   (SHIFT_BITS'(CNT_BITS - 1 - DIV_PER_STAGE * j)),
				.out_valid (div_v[j]),
				.out_d     (div_d[j])
			);
		end
	end

	// ------------------------------------------------------------------
	// Decay select and increment base
	// ------------------------------------------------------------------
	assign last_d = div_d[DIV_STAGES-1];

	always_comb begin
		if (last_d.keep) begin
			dec_nxt = last_d.count;
		end else if (last_d.sat || (last_d.quo > last_d.count)) begin
			dec_nxt = '0;
		end else begin
			dec_nxt = last_d.count - last_d.quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= div_v[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && div_v[DIV_STAGES-1]) begin
			dec_s6  <= dec_nxt;
			base_s6 <= (dec_nxt > CNT_BASE) ? dec_nxt - CNT_BASE : '0;
			rnd_s6  <= last_d.rnd;
			now_s6  <= last_d.now;
		end
	end

	// ------------------------------------------------------------------
	// Multiply: base * log_factor, then r * (that + 1)
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			dec_s7   <= dec_s6;
			scale_s7 <= PROD_BITS'(base_s6) * PROD_BITS'(log_factor_q);
			rnd_s7   <= rnd_s6;
			now_s7   <= now_s6;
		end
	end

	// base is at most 250, so the denominator cannot overflow
	assign denom = scale_s7 + PROD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8 && v_s7) begin
			dec_s8  <= dec_s7;
			test_s8 <= TEST_BITS'(rnd_s7) * TEST_BITS'(denom);
			now_s8  <= now_s7;
		end
	end

	// ------------------------------------------------------------------
	// Increment decision and output register
	// ------------------------------------------------------------------
	assign take = (dec_s8 != CNT_MAX) && (test_s8[TEST_BITS-1:RANDOM_BITS] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en_s9) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9 && v_s8) begin
			dec_s9 <= dec_s8;
			cnt_s9 <= dec_s8 + CNT_BITS'(take);
			inc_s9 <= take;
			now_s9 <= now_s8;
		end
	end

	assign result.valid         = v_s9;
	assign result.decayed_count = dec_s9;
	assign result.count_out     = cnt_s9;
	assign result.incremented   = inc_s9;
	assign result.stamp_out     = now_s9;

endmodule
